// ===== rtl/hexp_pkg.sv =====
// Shared types, constants and helpers for the hex text to bytes parser.
package hexp_pkg;

   localparam int INDEX_W = 15;
   localparam int LIMIT_W = 17;
   localparam int VALUE_W = 32;

   localparam logic [3:0] DIGIT_SAT = 4'd9;

   localparam logic CMD_CHAR = 1'b0;
   localparam logic CMD_EOF  = 1'b1;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_HASH  = 8'h23;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_LONG = 2'd1,
      KIND_BAD  = 2'd2,
      KIND_END  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      TRAIL_NONE = 2'd0,
      TRAIL_BAD  = 2'd1,
      TRAIL_END  = 2'd2
   } trail_type;

   // One flushed token plus whatever the ending character reports.
   // value is left aligned: the first byte to send sits in [31:24].
   typedef struct packed {
      logic [2:0]         num_bytes;
      logic               too_long;
      trail_type          trail;
      logic [VALUE_W-1:0] value;
   } job_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] nibble_of(input logic [7:0] c);
      logic [7:0] d;
      if (c <= 8'h39) begin
         d = c - 8'h30;
      end else if (c <= 8'h46) begin
         d = c - 8'h37;
      end else begin
         d = c - 8'h57;
      end
      return d[3:0];
   endfunction

endpackage

// ===== rtl/hexp_front.sv =====
// Front end: takes characters, builds hex tokens and queues flush jobs.
module hexp_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic             command,
   input  logic [7:0]       character,
   output logic             push,
   output hexp_pkg::job_type job
);
   import hexp_pkg::*;

   logic               comment_ff, comment_in;
   logic [3:0]         count_ff, count_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   job_type            flush_job;
   logic               blank;
   logic               comment_start;

   always_comb begin
      flush_job.too_long = (count_ff >= DIGIT_SAT);
      flush_job.trail    = TRAIL_NONE;
      case (count_ff)
         4'd0: begin
            flush_job.num_bytes = 3'd0;
            flush_job.value     = value_ff;
         end
         4'd1, 4'd2: begin
            flush_job.num_bytes = 3'd1;
            flush_job.value     = {value_ff[7:0], 24'h0};
         end
         4'd3, 4'd4: begin
            flush_job.num_bytes = 3'd2;
            flush_job.value     = {value_ff[15:0], 16'h0};
         end
         4'd5, 4'd6, 4'd7, 4'd8: begin
            flush_job.num_bytes = 3'd4;
            flush_job.value     = value_ff;
         end
         default: begin
            flush_job.num_bytes = 3'd0;
            flush_job.value     = value_ff;
         end
      endcase
   end

   assign blank = (character == CHAR_SPACE) || (character == CHAR_TAB) ||
                  (character == CHAR_LF) || (character == CHAR_CR);
   assign comment_start = (character == CHAR_HASH) || (character == CHAR_NUL);

   always_comb begin
      comment_in = comment_ff;
      count_in   = count_ff;
      value_in   = value_ff;
      job        = flush_job;
      push       = 1'b0;
      if (accept) begin
         if (command == CMD_EOF) begin
            job.trail  = TRAIL_END;
            push       = 1'b1;
            comment_in = 1'b0;
            count_in   = 4'd0;
            value_in   = '0;
         end else if (comment_ff) begin
            if (character == CHAR_LF) begin
               comment_in = 1'b0;
            end
         end else if (is_hex(character)) begin
            value_in = {value_ff[VALUE_W-5:0], nibble_of(character)};
            if (count_ff < DIGIT_SAT) begin
               count_in = count_ff + 4'd1;
            end
         end else begin
            if (comment_start) begin
               comment_in = 1'b1;
            end else if (!blank) begin
               job.trail = TRAIL_BAD;
            end
            push     = (job.num_bytes != 3'd0) || job.too_long || (job.trail != TRAIL_NONE);
            count_in = 4'd0;
            value_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         comment_ff <= 1'b0;
         count_ff   <= 4'd0;
         value_ff   <= '0;
      end else begin
         comment_ff <= comment_in;
         count_ff   <= count_in;
         value_ff   <= value_in;
      end
   end

endmodule

// ===== rtl/hexp_fifo.sv =====
// Short job queue between the front end and the byte expander.
module hexp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  hexp_pkg::job_type push_job,
   input  logic              pop,
   output hexp_pkg::job_type head_job,
   output logic              empty,
   output logic              full
);
   import hexp_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign empty    = (count_ff == CNT_W'(0));
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// ===== rtl/hexp_back.sv =====
// Back end: expands queued jobs into result beats and holds the byte count.
module hexp_back #(
   parameter int MAX_PACKET_BYTES = 16384
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [hexp_pkg::INDEX_W-1:0] packet_length,
   input  hexp_pkg::job_type            head_job,
   input  logic                         queue_empty,
   output logic                         pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_byte_value,
   output logic [hexp_pkg::INDEX_W-1:0] rsp_byte_index,
   output logic                         rsp_last
);
   import hexp_pkg::*;

   localparam logic [LIMIT_W-1:0] MaxLimit = LIMIT_W'(MAX_PACKET_BYTES);

   // current job
   logic               job_valid_ff, job_valid_in;
   logic [2:0]         rem_ff, rem_in;
   logic               long_ff, long_in;
   trail_type          trail_ff, trail_in;
   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [INDEX_W-1:0] written_ff, written_in;

   // output register
   logic               out_valid_ff, out_valid_in;
   kind_type           kind_ff, kind_in;
   logic [7:0]         byte_ff, byte_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               last_ff, last_in;

   logic [LIMIT_W-1:0] limit;
   logic [LIMIT_W-1:0] written_ext;
   logic               room;
   logic               data_ok;
   logic               has_result;
   logic               load;
   logic               emit;
   logic               emit_last;
   logic               job_done;

   assign limit = (LIMIT_W'(packet_length) < MaxLimit) ? LIMIT_W'(packet_length) : MaxLimit;
   assign written_ext = LIMIT_W'(written_ff);
   assign room        = written_ext < limit;
   assign data_ok     = (rem_ff != 3'd0) && room;
   assign has_result  = data_ok || long_ff || (trail_ff != TRAIL_NONE);
   assign load        = !out_valid_ff || !rsp_stall;
   assign emit        = job_valid_ff && has_result && load;

   always_comb begin
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      index_in  = index_ff;
      emit_last = 1'b1;
      if (data_ok) begin
         kind_in   = KIND_DATA;
         byte_in   = shift_ff[VALUE_W-1 -: 8];
         index_in  = written_ff;
         // later bytes of this token are dropped once the packet is full
         emit_last = !long_ff && (trail_ff == TRAIL_NONE) &&
                     ((rem_ff == 3'd1) || ((written_ext + LIMIT_W'(1)) >= limit));
      end else if (long_ff) begin
         kind_in   = KIND_LONG;
         byte_in   = 8'h00;
         index_in  = '0;
         emit_last = (trail_ff == TRAIL_NONE);
      end else if (trail_ff == TRAIL_BAD) begin
         kind_in  = KIND_BAD;
         byte_in  = 8'h00;
         index_in = '0;
      end else begin
         kind_in  = KIND_END;
         byte_in  = 8'h00;
         index_in = written_ff;
      end
      last_in = emit_last;
   end

   // a job with nothing left to report retires without a beat
   assign job_done = job_valid_ff && (!has_result || (load && emit_last));
   assign pop      = (!job_valid_ff || job_done) && !queue_empty;

   always_comb begin
      job_valid_in = job_valid_ff;
      rem_in       = rem_ff;
      long_in      = long_ff;
      trail_in     = trail_ff;
      shift_in     = shift_ff;
      written_in   = written_ff;
      if (emit) begin
         if (data_ok) begin
            rem_in     = rem_ff - 3'd1;
            shift_in   = {shift_ff[VALUE_W-9:0], 8'h00};
            written_in = written_ff + INDEX_W'(1);
         end else if (long_ff) begin
            long_in = 1'b0;
         end else begin
            trail_in = TRAIL_NONE;
            if (trail_ff == TRAIL_END) begin
               written_in = '0;
            end
         end
      end
      if (!job_valid_ff || job_done) begin
         job_valid_in = !queue_empty;
         rem_in       = head_job.num_bytes;
         long_in      = head_job.too_long;
         trail_in     = head_job.trail;
         shift_in     = head_job.value;
      end
   end

   always_comb begin
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (load) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
         written_ff   <= '0;
         long_ff      <= 1'b0;
         trail_ff     <= TRAIL_NONE;
         rem_ff       <= 3'd0;
      end else begin
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
         written_ff   <= written_in;
         long_ff      <= long_in;
         trail_ff     <= trail_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      if (emit) begin
         kind_ff  <= kind_in;
         byte_ff  <= byte_in;
         index_ff <= index_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_byte_value = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_last       = last_ff;

endmodule

// ===== rtl/hex_text_to_bytes_parser_unit.sv =====
// Top level of the hex text to bytes parser: front end, job queue, expander.
//
//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_command, req_character
//  rsp      out        rsp_valid/rsp_stall  rsp_kind, rsp_byte_value, rsp_byte_index, rsp_last
//  csr      in         csr_write_enable     csr_packet_length
//
// One character beat is taken per cycle while the job queue has room.
// A flushed token leaves one result beat per cycle from the expander while rsp_stall is low (up to five per job).
// Result beats sit in an output register; a stall there backs up into the queue, and into req_stall once it is full.
// req_stall rises when the job queue is full. Synchronous reset, no clearing pass.
module hex_text_to_bytes_parser_unit #(
   parameter int MAX_PACKET_BYTES = 16384,
   parameter int QUEUE_DEPTH      = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_command,
   input  logic [7:0]                   req_character,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_kind,
   output logic [7:0]                   rsp_byte_value,
   output logic [hexp_pkg::INDEX_W-1:0] rsp_byte_index,
   output logic                         rsp_last,
   input  logic                         csr_write_enable,
   input  logic [hexp_pkg::INDEX_W-1:0] csr_packet_length
);
   import hexp_pkg::*;

   logic [INDEX_W-1:0] packet_length_ff, packet_length_in;
   logic               accept;
   logic               push;
   logic               pop;
   job_type            push_job;
   job_type            head_job;
   logic               queue_empty;
   logic               queue_full;

   assign packet_length_in = csr_write_enable ? csr_packet_length : packet_length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         packet_length_ff <= INDEX_W'(1024);
      end else begin
         packet_length_ff <= packet_length_in;
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   hexp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .command   (req_command),
      .character (req_character),
      .push      (push),
      .job       (push_job)
   );

   hexp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (queue_empty),
      .full     (queue_full)
   );

   hexp_back #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .packet_length  (packet_length_ff),
      .head_job       (head_job),
      .queue_empty    (queue_empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_byte_value (rsp_byte_value),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last)
   );

   // data bytes never reach past the configured length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_DATA) |-> (rsp_byte_index < packet_length_ff))
      else $error("data byte index beyond packet length");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_kind == KIND_LONG || rsp_kind == KIND_BAD)) |->
      (rsp_byte_index == '0 && rsp_byte_value == 8'h00))
      else $error("warning beat carries nonzero payload");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_END) |-> (rsp_last && rsp_byte_value == 8'h00))
      else $error("packet end beat not marked last");

   // a packet end restarts byte numbering
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_kind == KIND_END) |=>
      (!rsp_valid || rsp_kind != KIND_DATA || rsp_byte_index == '0))
      else $error("byte index not restarted after packet end");

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the hex text to bytes parser: text beats in, checked result beats out.
module tb_top;
   import hexp_pkg::*;

   localparam int MAX_BYTES   = 16384;
   localparam int DRAIN_WAIT  = 40;
   localparam int HOLD_CYCLES = 300;
   localparam int STUCK_LIMIT = 2000;
   localparam int GAP_PCT     = 21;

   typedef struct {
      logic       command;
      logic [7:0] character;
   } text_beat_type;

   typedef struct {
      kind_type           kind;
      logic [7:0]         byte_value;
      logic [INDEX_W-1:0] byte_index;
      logic               last;
   } parse_result_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic               req_command = CMD_CHAR;
   logic [7:0]         req_character = 8'h00;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [1:0]         rsp_kind;
   logic [7:0]         rsp_byte_value;
   logic [INDEX_W-1:0] rsp_byte_index;
   logic               rsp_last;
   logic               csr_write_enable = 1'b0;
   logic [INDEX_W-1:0] csr_packet_length = '0;

   text_beat_type    text_queue[$];
   parse_result_type parse_results[$];

   // parser shadow state
   logic               in_comment = 1'b0;
   logic [3:0]         digits = '0;
   logic [31:0]        token = '0;
   logic [INDEX_W-1:0] written = '0;
   logic [INDEX_W-1:0] length_reg = 15'd1024;

   bit steady = 1'b0;
   int holds_asked = 0;
   int errors = 0;
   int beats_in = 0;
   int beats_out = 0;
   int data_seen = 0;
   int warn_seen = 0;
   int ends_seen = 0;

   hex_text_to_bytes_parser_unit uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_character     (req_character),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_kind          (rsp_kind),
      .rsp_byte_value    (rsp_byte_value),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_last          (rsp_last),
      .csr_write_enable  (csr_write_enable),
      .csr_packet_length (csr_packet_length)
   );

   always #5 clock = ~clock;

   function automatic void push_result(kind_type k, logic [7:0] v, logic [INDEX_W-1:0] idx);
      parse_result_type r;
      r.kind       = k;
      r.byte_value = v;
      r.byte_index = idx;
      r.last       = 1'b0;
      parse_results.push_back(r);
   endfunction

   function automatic void emit_byte(logic [7:0] v);
      int limit;
      limit = (int'(length_reg) > MAX_BYTES) ? MAX_BYTES : int'(length_reg);
      if (int'(written) < limit) begin
         push_result(KIND_DATA, v, written);
         written = written + 1'b1;
      end
   endfunction

   function automatic void flush_token();
      if (digits == 0) begin
         // nothing pending
      end else if (digits <= 2) begin
         emit_byte(token[7:0]);
      end else if (digits <= 4) begin
         emit_byte(token[15:8]);
         emit_byte(token[7:0]);
      end else if (digits <= 8) begin
         emit_byte(token[31:24]);
         emit_byte(token[23:16]);
         emit_byte(token[15:8]);
         emit_byte(token[7:0]);
      end else begin
         push_result(KIND_LONG, 8'h00, '0);
      end
      digits = '0;
      token  = '0;
   endfunction

   function automatic bit hex_value(input logic [7:0] ch, output logic [3:0] nib);
      logic [7:0] d;
      d = 8'h00;
      hex_value = 1'b1;
      if (ch >= 8'h30 && ch <= 8'h39) d = ch - 8'h30;
      else if (ch >= 8'h41 && ch <= 8'h46) d = ch - 8'h41 + 8'd10;
      else if (ch >= 8'h61 && ch <= 8'h66) d = ch - 8'h61 + 8'd10;
      else hex_value = 1'b0;
      nib = d[3:0];
   endfunction

   // Work out the result beats one accepted text beat causes.
   function automatic void parse_char(input logic cmd, input logic [7:0] ch);
      int start_n;
      logic [3:0] nib;
      parse_result_type tail;
      start_n = parse_results.size();
      if (cmd == CMD_EOF) begin
         flush_token();
         push_result(KIND_END, 8'h00, written);
         in_comment = 1'b0;
         digits     = '0;
         token      = '0;
         written    = '0;
      end else if (in_comment) begin
         if (ch == CHAR_LF) in_comment = 1'b0;
      end else if (hex_value(ch, nib)) begin
         token = {token[27:0], nib};
         if (digits < DIGIT_SAT) digits = digits + 1'b1;
      end else begin
         flush_token();
         if (ch == CHAR_HASH || ch == CHAR_NUL) begin
            in_comment = 1'b1;
         end else if (!(ch == CHAR_SPACE || ch == CHAR_TAB || ch == CHAR_CR ||
                        ch == CHAR_LF)) begin
            push_result(KIND_BAD, 8'h00, '0);
         end
      end
      if (parse_results.size() > start_n) begin
         tail = parse_results.pop_back();
         tail.last = 1'b1;
         parse_results.push_back(tail);
      end
   endfunction

   // Sender: one beat offered at a time, held while stalled.
   always @(posedge clock) begin : driver
      text_beat_type nxt;
      bit take;
      bit gap;
      take = req_valid && !req_stall && !reset;
      if (take) begin
         parse_char(req_command, req_character);
         beats_in++;
      end
      gap = !steady && ($urandom_range(0, 99) < GAP_PCT);
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || take) begin
         if (text_queue.size() != 0 && !gap) begin
            nxt = text_queue.pop_front();
            req_valid     <= 1'b1;
            req_command   <= nxt.command;
            req_character <= nxt.character;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: checks each result beat, random stalls plus long hold-offs on request.
   always @(posedge clock) begin : monitor
      parse_result_type want;
      int hold_left;
      int holds_done;
      if (reset) begin
         hold_left  = 0;
         holds_done = 0;
      end else if (rsp_valid && !rsp_stall) begin
         beats_out++;
         case (rsp_kind)
            KIND_DATA: data_seen++;
            KIND_END:  ends_seen++;
            default:   warn_seen++;
         endcase
         if (parse_results.size() == 0) begin
            $error("unexpected result beat: kind %0d value %0h index %0d", rsp_kind,
                   rsp_byte_value, rsp_byte_index);
            errors++;
         end else begin
            want = parse_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_kind);
               errors++;
            end
            if (rsp_byte_value !== want.byte_value) begin
               $error("byte_value: expected %0h, got %0h", want.byte_value, rsp_byte_value);
               errors++;
            end
            if (rsp_byte_index !== want.byte_index) begin
               $error("byte_index: expected %0d, got %0d", want.byte_index, rsp_byte_index);
               errors++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_last);
               errors++;
            end
         end
      end
      if (!reset && holds_done != holds_asked) begin
         hold_left = HOLD_CYCLES;
         holds_done++;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(0, 99) < GAP_PCT);
      end
   end

   always @(posedge clock) begin : watchdog
      int stuck;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck = 0;
      end else begin
         stuck++;
         if (stuck >= STUCK_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STUCK_LIMIT);
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic put_char(input logic [7:0] c);
      text_beat_type b;
      b.command   = CMD_CHAR;
      b.character = c;
      text_queue.push_back(b);
   endtask

   task automatic put_eof();
      text_beat_type b;
      b.command   = CMD_EOF;
      b.character = 8'($urandom_range(0, 255));
      text_queue.push_back(b);
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endtask

   function automatic logic [7:0] hex_char(input int i);
      string digit_set;
      digit_set = "0123456789abcdefABCDEF";
      return digit_set[i];
   endfunction

   function automatic logic [7:0] blank_char(input int i);
      case (i)
         0: return CHAR_SPACE;
         1: return CHAR_TAB;
         2: return CHAR_CR;
         default: return CHAR_LF;
      endcase
   endfunction

   // Mostly well-formed tokens and comments, with noise and stray EOFs mixed in.
   task automatic gen_text(input int want);
      int made;
      int r;
      int len;
      made = 0;
      while (made < want) begin
         r = $urandom_range(0, 99);
         if (r < 60) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
            repeat (len) put_char(hex_char($urandom_range(0, 21)));
            r = $urandom_range(0, 9);
            if (r < 7) put_char(blank_char($urandom_range(0, 3)));
            else if (r == 7) put_char(CHAR_HASH);
            else put_char(8'($urandom_range(0, 255)));
            made += len + 1;
         end else if (r < 72) begin
            put_char((r < 66) ? CHAR_HASH : CHAR_NUL);
            repeat ($urandom_range(0, 4)) put_char(8'($urandom_range(0, 255)));
            put_char(CHAR_LF);
            made++;
         end else if (r < 95) begin
            put_char(8'($urandom_range(0, 255)));
            made++;
         end else begin
            put_eof();
            made++;
         end
      end
      put_eof();
   endtask

   // Wait until every beat is sent and answered, then let the pipeline drain.
   task automatic settle();
      while (text_queue.size() != 0 || req_valid || parse_results.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   task automatic write_packet_length(input logic [INDEX_W-1:0] v);
      @(posedge clock);
      csr_write_enable  <= 1'b1;
      csr_packet_length <= v;
      @(posedge clock);
      csr_write_enable  <= 1'b0;
      length_reg = v;
      @(negedge clock);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: byte extremes, token sizes, blanks, comments, high codes, too-long flush
      put_text("0\tFf#\naBc");
      put_char(8'hFF);
      put_text("12345");
      put_char(CHAR_NUL);
      put_char(CHAR_LF);
      put_text("999999999");
      put_eof();
      settle();

      write_packet_length(15'd0);
      gen_text(12);
      settle();

      write_packet_length(15'h7FFF);
      steady = 1'b1;
      gen_text(40);
      settle();
      steady = 1'b0;

      // long receiver hold-off while the sender keeps offering
      write_packet_length(15'd16384);
      holds_asked++;
      gen_text(40);
      settle();

      write_packet_length(15'd5);
      gen_text(28);
      settle();

      repeat (4) begin
         write_packet_length(15'($urandom_range(1, 48)));
         gen_text(9);
         settle();
      end

      if (parse_results.size() != 0) begin
         $error("%0d expected result beats never arrived", parse_results.size());
         errors++;
      end
      $display("covered %0d text beats and %0d result beats: %0d data, %0d warnings, %0d ends",
               beats_in, beats_out, data_seen, warn_seen, ends_seen);
      $display("packet lengths 0, 5, 16384, 32767 and small random ones, one long hold-off");
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/hexp_pkg.sv
rtl/hexp_front.sv
rtl/hexp_fifo.sv
rtl/hexp_back.sv
rtl/hex_text_to_bytes_parser_unit.sv
bench/tb_top.sv
